// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers included by the tracker unit rtl
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property checked at every rising clock edge outside reset
`define ASSERT_CLK(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");

// condition that must never be true outside reset
`define ASSERT_NEVER(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("forbidden condition seen");

`else

`define ASSERT_CLK(label, clk, rst, prop)
`define ASSERT_NEVER(label, clk, rst, cond)

`endif

`endif

// ===== hw/rtl/plht_pkg.sv =====
// ----------------------------------------------------------------------------
// plht_pkg
// constants, types and the boundary table of the percent level tracker
// ----------------------------------------------------------------------------
`default_nettype none

package plht_pkg;

   localparam int NUM_CHANNELS = 2;
   localparam int SAMPLE_BITS  = 12;
   localparam int CHANNEL_W    = 1;
   localparam int LEVEL_W      = 7;
   localparam int BAND_W       = 7;
   localparam int PCT_MAX      = 100;
   localparam int BAND_RESET   = 5;

   localparam int FULL_SCALE   = (1 << SAMPLE_BITS) - 1;
   // table entries reach 127 percent of full scale
   localparam int BOUND_W      = SAMPLE_BITS + 1;
   // one bit more for sums of two table entries
   localparam int EXT_W        = BOUND_W + 1;
   // sample*100 and level*full_scale
   localparam int PROD_W       = SAMPLE_BITS + LEVEL_W;
   localparam int TABLE_DEPTH  = 1 << LEVEL_W;

   typedef logic [CHANNEL_W-1:0]   channel_type;
   typedef logic [SAMPLE_BITS-1:0] sample_type;
   typedef logic [LEVEL_W-1:0]     level_type;
   typedef logic [BAND_W-1:0]      band_type;
   typedef logic [BOUND_W-1:0]     bound_type;
   typedef bound_type [TABLE_DEPTH-1:0] bound_table_type;

   localparam level_type LEVEL_MAX       = LEVEL_W'(PCT_MAX);
   localparam level_type LEVEL_BELOW_MAX = LEVEL_W'(PCT_MAX - 1);

   // entry i is i*full_scale/100, used for level boundaries and the band
   function automatic bound_table_type build_bound_table();
      bound_table_type tbl;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         tbl[i] = BOUND_W'((i * FULL_SCALE) / PCT_MAX);
      end
      return tbl;
   endfunction

   localparam bound_table_type BOUND_TABLE = build_bound_table();

endpackage

`default_nettype wire

// ===== hw/rtl/plht_req_if.sv =====
// ----------------------------------------------------------------------------
// plht_req_if
// sample channel: valid/ready handshake with channel index and raw sample
// ----------------------------------------------------------------------------
`default_nettype none

interface plht_req_if;
   import plht_pkg::*;

   logic        valid;
   logic        ready;
   channel_type channel;
   sample_type  sample;

   modport source (output valid, output channel, output sample, input ready);
   modport sink   (input valid, input channel, input sample, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/plht_rsp_if.sv =====
// ----------------------------------------------------------------------------
// plht_rsp_if
// level channel: valid/ready handshake with channel index and percent level
// ----------------------------------------------------------------------------
`default_nettype none

interface plht_rsp_if;
   import plht_pkg::*;

   logic        valid;
   logic        ready;
   channel_type level_channel;
   level_type   level;

   modport source (output valid, output level_channel, output level, input ready);
   modport sink   (input valid, input level_channel, input level, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/plht_level_calc.sv =====
// ----------------------------------------------------------------------------
// plht_level_calc
// next level of one channel from its current level, a sample and the band
// ----------------------------------------------------------------------------
`default_nettype none

module plht_level_calc (
   input  wire plht_pkg::level_type  level_cur,
   input  wire plht_pkg::sample_type sample,
   input  wire plht_pkg::bound_type  band_h,
   output plht_pkg::level_type       level_next
);
   import plht_pkg::*;

   logic [PROD_W-1:0] sample_x100;
   logic [PROD_W-1:0] upper_pct_bound;
   logic [PROD_W-1:0] lower_pct_bound;
   logic              pct_above;
   logic              pct_below;
   level_type         level_up;
   logic [EXT_W-1:0]  band_ext;
   logic [EXT_W-1:0]  full_ext;
   logic [EXT_W-1:0]  top_thr;
   logic [EXT_W-1:0]  rise_sum;
   logic [EXT_W-1:0]  rise_thr;
   logic [EXT_W-1:0]  fall_base;
   logic [EXT_W-1:0]  fall_thr;
   logic [EXT_W-1:0]  sample_ext;

   always_comb begin
      level_up   = level_type'(level_cur + 1'b1);
      band_ext   = EXT_W'(band_h);
      full_ext   = EXT_W'(FULL_SCALE);
      sample_ext = EXT_W'(sample);

      // instantaneous percent compared against the level without dividing
      sample_x100     = PROD_W'(sample) * PROD_W'(PCT_MAX);
      upper_pct_bound = PROD_W'(level_up) * PROD_W'(FULL_SCALE);
      lower_pct_bound = PROD_W'(level_cur) * PROD_W'(FULL_SCALE);
      pct_above       = sample_x100 >= upper_pct_bound;
      pct_below       = sample_x100 < lower_pct_bound;

      top_thr   = (full_ext > band_ext) ? (full_ext - band_ext) : '0;

      rise_sum  = EXT_W'(BOUND_TABLE[level_up]) + band_ext;
      rise_thr  = (rise_sum > full_ext) ? full_ext : rise_sum;

      fall_base = EXT_W'(BOUND_TABLE[level_cur]);
      fall_thr  = (fall_base > band_ext) ? (fall_base - band_ext) : '0;

      if (level_cur >= LEVEL_MAX) begin
         level_next = (sample_ext < top_thr) ? LEVEL_BELOW_MAX : LEVEL_MAX;
      end else if (pct_above) begin
         level_next = (sample_ext >= rise_thr) ? level_up : level_cur;
      end else if (pct_below) begin
         level_next = (sample_ext < fall_thr) ? level_type'(level_cur - 1'b1) : level_cur;
      end else begin
         level_next = level_cur;
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/percent_level_hysteresis_tracker_unit.sv =====
// ----------------------------------------------------------------------------
// percent_level_hysteresis_tracker_unit
// output: the level is computed from the input register and held in the output register
// throughput: one sample per cycle while the output register is free or read, set by the input and output registers
// around the single-pass level update; a waiting level blocks input only
// once the input register holds a sample too
// reset: levels of all channels clear to 0, band returns to 5 percent
// ----------------------------------------------------------------------------
`default_nettype none

module percent_level_hysteresis_tracker_unit (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     csr_write_enable,
   input  wire plht_pkg::band_type csr_write_data,
   plht_req_if.sink                req_bus,
   plht_rsp_if.source              rsp_bus
);
   import plht_pkg::*;

   `include "assert_macros.svh"

   bound_type   band_h_ff;
   bound_type   band_h_in;

   logic        in_vld_ff;
   logic        in_vld_in;
   channel_type in_channel_ff;
   channel_type in_channel_in;
   sample_type  in_sample_ff;
   sample_type  in_sample_in;

   logic        out_vld_ff;
   logic        out_vld_in;
   channel_type out_channel_ff;
   channel_type out_channel_in;
   level_type   out_level_ff;
   level_type   out_level_in;

   level_type [NUM_CHANNELS-1:0] level_ff;
   level_type [NUM_CHANNELS-1:0] level_in;

   logic        req_take;
   logic        advance;
   logic        chan_known;
   level_type   level_cur;
   level_type   level_next;

   assign advance        = in_vld_ff && (!out_vld_ff || rsp_bus.ready);
   assign req_bus.ready  = !in_vld_ff || !out_vld_ff || rsp_bus.ready;
   assign req_take       = req_bus.valid && req_bus.ready;

   assign rsp_bus.valid         = out_vld_ff;
   assign rsp_bus.level_channel = out_channel_ff;
   assign rsp_bus.level         = out_level_ff;

   // pick the stored level of the addressed channel
   always_comb begin
      level_cur  = '0;
      chan_known = 1'b0;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
         if (32'(in_channel_ff) == i) begin
            level_cur  = level_ff[i];
            chan_known = 1'b1;
         end
      end
   end

   plht_level_calc u_level_calc (
      .level_cur  (level_cur),
      .sample     (in_sample_ff),
      .band_h     (band_h_ff),
      .level_next (level_next)
   );

   always_comb begin
      band_h_in = csr_write_enable ? BOUND_TABLE[csr_write_data] : band_h_ff;

      in_vld_in     = req_take || (in_vld_ff && !advance);
      in_channel_in = req_take ? req_bus.channel : in_channel_ff;
      in_sample_in  = req_take ? req_bus.sample : in_sample_ff;

      out_vld_in     = advance || (out_vld_ff && !rsp_bus.ready);
      out_channel_in = advance ? in_channel_ff : out_channel_ff;
      // unknown channel reports level 0 and leaves all state alone
      out_level_in   = advance ? (chan_known ? level_next : '0) : out_level_ff;

      for (int i = 0; i < NUM_CHANNELS; i++) begin
         level_in[i] = (advance && 32'(in_channel_ff) == i) ? level_next : level_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         band_h_ff  <= BOUND_TABLE[BAND_RESET];
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
         level_ff   <= '0;
      end else begin
         band_h_ff  <= band_h_in;
         in_vld_ff  <= in_vld_in;
         out_vld_ff <= out_vld_in;
         level_ff   <= level_in;
      end
   end

   always_ff @(posedge clock) begin
      in_channel_ff  <= in_channel_in;
      in_sample_ff   <= in_sample_in;
      out_channel_ff <= out_channel_in;
      out_level_ff   <= out_level_in;
   end

   `ASSERT_NEVER(a_level_range, clock, reset, rsp_bus.valid && rsp_bus.level > LEVEL_MAX)
   `ASSERT_CLK(a_ready_when_out_free, clock, reset, !out_vld_ff |-> req_bus.ready)
   `ASSERT_CLK(a_rsp_from_input_stage, clock, reset, $rose(rsp_bus.valid) |-> $past(in_vld_ff))
   `ASSERT_CLK(a_level_single_step, clock, reset, !$past(reset) |-> (level_ff[0] == $past(level_ff[0]) || level_ff[0] == $past(level_ff[0]) + 1'b1 || level_ff[0] + 1'b1 == $past(level_ff[0])))

endmodule

`default_nettype wire
